### hw/rtl/jfop_pkg.sv
// Package: shared types and codes for the flat JSON object parser.
`timescale 1ns / 1ps
package jfop_pkg;
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] event_kind;
		logic       run_end;
	} out_word_t;

	localparam logic [2:0] EV_KEY_BYTE  = 3'd0;
	localparam logic [2:0] EV_VAL_BYTE  = 3'd1;
	localparam logic [2:0] EV_KEY_END   = 3'd2;
	localparam logic [2:0] EV_ENTRY_END = 3'd3;
	localparam logic [2:0] EV_OK        = 3'd4;
	localparam logic [2:0] EV_ERROR     = 3'd5;

	// command from front to back: a pending flush, up to three direct bytes, then a tail of up to two events
	typedef struct packed {
		logic [1:0] n_direct;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [2:0] kind;
		logic       flush;
		logic       flush_bank;
		logic [5:0] flush_cnt;
		logic       has_t1;
		logic [2:0] t1;
		logic       has_t2;
		logic [2:0] t2;
		logic       last_bare;
	} cmd_t;
endpackage

### hw/rtl/jfop_front.sv
// Front end: phase machine that classifies each text byte into an emit command.
`timescale 1ns / 1ps
module jfop_front #(
	parameter int PEND_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  jfop_pkg::in_word_t in_word,
	input  logic               in_take,
	output jfop_pkg::cmd_t     cmd,
	output logic               pend_wr,
	output logic [7:0]         pend_data,
	output logic [5:0]         pend_idx,
	output logic               pend_bank
);
	import jfop_pkg::*;

	localparam logic [3:0] PH_WAIT_OPEN = 4'd0, PH_OBJ_START = 4'd1, PH_KEY_WAIT = 4'd2,
		PH_KEY = 4'd3, PH_KEY_ESC = 4'd4, PH_KEY_HEX = 4'd5, PH_COLON = 4'd6,
		PH_VAL_WAIT = 4'd7, PH_VAL = 4'd8, PH_VAL_ESC = 4'd9, PH_VAL_HEX = 4'd10,
		PH_BARE = 4'd11, PH_AFTER_VAL = 4'd12, PH_DONE = 4'd13;

	logic [3:0]  phase_q, ph_n;
	logic [2:0]  hex_q, hex_n;
	logic [15:0] cp_q, cp_n;
	logic [5:0]  pcnt_q, pcnt_n;
	logic        bank_q, bank_n;

	logic [7:0]  c;
	logic        ws, comma_now, err, ok;
	logic [4:0]  hv;
	logic        is_val;
	logic [15:0] cpx;
	logic [3:0]  base;

	assign c = in_word.text_byte;
	assign ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);

	always_comb begin
		if (c inside {["0":"9"]}) hv = {1'b0, c[3:0]};
		else if (c inside {["a":"f"], ["A":"F"]}) hv = {1'b0, c[3:0] + 4'd9};
		else hv = 5'h10;
	end

	// classify the byte against the current phase
	always_comb begin
		ph_n = phase_q; hex_n = hex_q; cp_n = cp_q; pcnt_n = pcnt_q; bank_n = bank_q;
		cmd = '0; comma_now = 1'b0; err = 1'b0; ok = 1'b0;
		pend_wr = 1'b0; pend_data = c; pend_idx = pcnt_q; pend_bank = bank_q;
		is_val = (phase_q >= PH_VAL); base = is_val ? PH_VAL : PH_KEY;
		cmd.kind = is_val ? EV_VAL_BYTE : EV_KEY_BYTE;
		cpx = {cp_q[11:0], hv[3:0]};
		case (phase_q)
			PH_WAIT_OPEN: begin
				if (c == "{") ph_n = PH_OBJ_START;
				else if (!ws) err = 1'b1;
			end
			PH_OBJ_START, PH_KEY_WAIT: begin
				if (c == "\"") ph_n = PH_KEY;
				else if (c == "}" && phase_q == PH_OBJ_START) ok = 1'b1;
				else if (!ws) err = 1'b1;
			end
			PH_KEY, PH_VAL: begin
				if (c == "\"") begin
					cmd.has_t1 = 1'b1; cmd.t1 = is_val ? EV_ENTRY_END : EV_KEY_END;
					ph_n = is_val ? PH_AFTER_VAL : PH_COLON;
				end else if (c == "\\") ph_n = base + 4'd1;
				else begin cmd.n_direct = 2'd1; cmd.b0 = c; end
			end
			PH_KEY_ESC, PH_VAL_ESC: begin
				if (c == "u") begin
					hex_n = '0; cp_n = '0; ph_n = base + 4'd2;
				end else begin
					cmd.n_direct = 2'd1; ph_n = base;
					case (c)
						"n": cmd.b0 = 8'h0A;
						"r": cmd.b0 = 8'h0D;
						"t": cmd.b0 = 8'h09;
						"b": cmd.b0 = 8'h08;
						"f": cmd.b0 = 8'h0C;
						default: cmd.b0 = c;
					endcase
				end
			end
			PH_KEY_HEX, PH_VAL_HEX: begin
				if (hv[4]) begin
					ph_n = base; hex_n = '0; cp_n = '0;
				end else if (hex_q == 3'd3) begin
					hex_n = '0; cp_n = '0; ph_n = base;
					if (cpx < 16'h0080) begin
						cmd.n_direct = 2'd1; cmd.b0 = cpx[7:0];
					end else if (cpx < 16'h0800) begin
						cmd.n_direct = 2'd2;
						cmd.b0 = 8'hC0 | {3'b0, cpx[10:6]};
						cmd.b1 = 8'h80 | {2'b0, cpx[5:0]};
					end else begin
						cmd.n_direct = 2'd3;
						cmd.b0 = 8'hE0 | {4'b0, cpx[15:12]};
						cmd.b1 = 8'h80 | {2'b0, cpx[11:6]};
						cmd.b2 = 8'h80 | {2'b0, cpx[5:0]};
					end
				end else begin
					cp_n = cpx; hex_n = hex_q + 3'd1;
				end
			end
			PH_COLON: begin
				if (c == ":") ph_n = PH_VAL_WAIT;
				else if (!ws) err = 1'b1;
			end
			PH_VAL_WAIT, PH_BARE: begin
				cmd.kind = EV_VAL_BYTE;
				if (c == "\"" && phase_q == PH_VAL_WAIT) ph_n = PH_VAL;
				else if (c == "," || c == "}") begin
					pcnt_n = '0; cmd.has_t1 = 1'b1; cmd.t1 = EV_ENTRY_END;
					if (c == ",") begin ph_n = PH_KEY_WAIT; comma_now = 1'b1; end
					else ok = 1'b1;
				end else if (ws) begin
					if (phase_q == PH_BARE) begin
						if (pcnt_q >= 6'(PEND_DEPTH)) begin pcnt_n = '0; err = 1'b1; end
						else begin pend_wr = 1'b1; pcnt_n = pcnt_q + 6'd1; end
					end
				end else begin
					// hand the held run to the back end and fill the other bank next
					cmd.flush = (pcnt_q != '0); cmd.flush_cnt = pcnt_q;
					cmd.flush_bank = bank_q;
					if (pcnt_q != '0) bank_n = ~bank_q;
					pcnt_n = '0; cmd.n_direct = 2'd1; cmd.b0 = c; ph_n = PH_BARE;
				end
			end
			PH_AFTER_VAL: begin
				if (c == ",") begin ph_n = PH_KEY_WAIT; comma_now = 1'b1; end
				else if (c == "}") ok = 1'b1;
				else if (!ws) err = 1'b1;
			end
			default: ;
		endcase
		// flush bytes come before the direct byte: front tells back via flush flag
		if (ok) ph_n = PH_DONE;
		if (err) ph_n = PH_DONE;
		if (ok || err) begin
			// slot t2 when t1 is already used
			if (cmd.has_t1) begin cmd.has_t2 = 1'b1; cmd.t2 = ok ? EV_OK : EV_ERROR; end
			else begin cmd.has_t1 = 1'b1; cmd.t1 = ok ? EV_OK : EV_ERROR; end
		end
		if (in_word.final_byte) begin
			if (ph_n != PH_DONE) begin
				if (cmd.has_t1) begin
					cmd.has_t2 = 1'b1;
					cmd.t2 = (ph_n == PH_OBJ_START || comma_now) ? EV_OK : EV_ERROR;
				end else begin
					cmd.has_t1 = 1'b1;
					cmd.t1 = (ph_n == PH_OBJ_START || comma_now) ? EV_OK : EV_ERROR;
				end
			end
			ph_n = PH_WAIT_OPEN; hex_n = '0; cp_n = '0; pcnt_n = '0;
		end
	end

	// advance the phase state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_OPEN; hex_q <= '0; cp_q <= '0; pcnt_q <= '0; bank_q <= 1'b0;
		end else if (in_take) begin
			phase_q <= ph_n; hex_q <= hex_n; cp_q <= cp_n; pcnt_q <= pcnt_n; bank_q <= bank_n;
		end
	end
endmodule

### hw/rtl/jfop_back.sv
// Back end: command queue, pending space store and result sequencer.
`timescale 1ns / 1ps
module jfop_back #(
	parameter int PEND_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  jfop_pkg::cmd_t      cmd,
	input  logic                cmd_push,
	output logic                cmd_full,
	input  logic                pend_wr,
	input  logic [7:0]          pend_data,
	input  logic [5:0]          pend_idx,
	input  logic                pend_bank,
	output jfop_pkg::out_word_t result,
	output logic                empty,
	input  logic                pop
);
	import jfop_pkg::*;

	localparam int IW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

	logic [7:0] pend_mem [2][PEND_DEPTH];
	cmd_t       qd [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       cur;
	logic [2:0] step_q;
	logic [5:0] fi_q;
	logic       ov_q;
	logic       busy_q;
	out_word_t  ow;
	out_word_t  res_q;
	logic       ow_last, has_cmd, load, nothing;
	logic [2:0] stp_n, first_step;
	logic [5:0] fi_n, rd_idx;
	logic [7:0] rd_q;

	// write held whitespace into the store
	always_ff @(posedge clk) begin
		if (pend_wr) pend_mem[pend_bank][pend_idx[IW-1:0]] <= pend_data;
	end

	// hold commands between front and back
	always_ff @(posedge clk) begin
		if (cmd_push && !cmd_full) qd[wp_q] <= cmd;
	end

	assign cmd_full = (cnt_q == 2'd2);
	assign has_cmd  = (cnt_q != '0);
	assign cur      = qd[rp_q];

	// sequence steps: 0 flush, 1..3 direct bytes, 4 tail one, 5 tail two
	always_comb begin
		ow = '0; ow_last = 1'b0; stp_n = step_q; fi_n = fi_q;
		case (step_q)
			3'd0: begin
				ow.out_byte = rd_q; ow.event_kind = EV_VAL_BYTE; fi_n = fi_q + 6'd1;
				if (fi_q + 6'd1 == cur.flush_cnt) stp_n = 3'd1;
			end
			3'd1: begin ow.out_byte = cur.b0; ow.event_kind = cur.kind; end
			3'd2: begin ow.out_byte = cur.b1; ow.event_kind = cur.kind; end
			3'd3: begin ow.out_byte = cur.b2; ow.event_kind = cur.kind; end
			3'd4: ow.event_kind = cur.t1;
			3'd5: ow.event_kind = cur.t2;
			default: ;
		endcase
		if (step_q >= 3'd1) begin
			if (step_q <= 3'd3 && step_q < 3'({1'b0, cur.n_direct})) stp_n = step_q + 3'd1;
			else if (step_q <= 3'd3 && cur.has_t1) stp_n = 3'd4;
			else if (step_q == 3'd4 && cur.has_t2) stp_n = 3'd5;
			else ow_last = 1'b1;
		end
		ow.run_end = ow_last;
	end

	// pick the first step of the command at the head of the queue
	always_comb begin
		nothing = !cur.flush && cur.n_direct == '0 && !cur.has_t1;
		if (cur.flush) first_step = 3'd0;
		else if (cur.n_direct != '0) first_step = 3'd1;
		else first_step = 3'd4;
	end

	// prefetch the held byte for the next flush step
	always_comb begin
		if (!busy_q) rd_idx = '0;
		else if (load) rd_idx = fi_n;
		else rd_idx = fi_q;
	end

	always_ff @(posedge clk) begin
		rd_q <= pend_mem[cur.flush_bank][rd_idx[IW-1:0]];
	end

	assign empty  = !ov_q;

	// output register holds one word, refilled as it drains
	assign result = res_q;
	assign load = busy_q && (!ov_q || pop);

	always_ff @(posedge clk) begin
		if (load) res_q <= ow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; step_q <= '0; fi_q <= '0;
			ov_q <= 1'b0; busy_q <= 1'b0;
		end else begin
			logic deq;
			deq = 1'b0;
			if (load) ov_q <= 1'b1;
			else if (pop) ov_q <= 1'b0;
			if (busy_q) begin
				if (load) begin
					step_q <= stp_n; fi_q <= fi_n;
					if (ow_last) begin busy_q <= 1'b0; deq = 1'b1; end
				end
			end else if (has_cmd) begin
				if (nothing) deq = 1'b1;
				else begin busy_q <= 1'b1; step_q <= first_step; fi_q <= '0; end
			end
			if (deq) rp_q <= ~rp_q;
			if (cmd_push && !cmd_full) wp_q <= ~wp_q;
			cnt_q <= cnt_q + 2'(cmd_push && !cmd_full) - 2'(deq);
		end
	end
endmodule

### hw/rtl/json_flat_object_parser_top.sv
// Top level: flat JSON object parser with string unescape.
// The back end opens each command before emitting its words, one word per cycle while pop keeps the
// output register free; the two-entry queue, which holds the command in progress, lets the front
// run up to two bytes ahead.
// Reset: arst_n clears phase, counters and queue pointers and marks the output register empty;
// the pending whitespace store and the output word itself are not cleared.
`timescale 1ns / 1ps
module json_flat_object_parser_top #(
	parameter int PEND_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  jfop_pkg::in_word_t  in_word,
	input  logic                push,
	output logic                full,
	output jfop_pkg::out_word_t result,
	output logic                empty,
	input  logic                pop
);
	import jfop_pkg::*;

	cmd_t       cmd;
	logic       pend_wr;
	logic       pend_wr_g;
	logic [7:0] pend_data;
	logic [5:0] pend_idx;
	logic       pend_bank;
	logic       take;

	assign take = push && !full;

	jfop_front #(.PEND_DEPTH(PEND_DEPTH)) u_front (
		.clk, .arst_n, .in_word, .in_take(take), .cmd,
		.pend_wr(pend_wr_g), .pend_data, .pend_idx, .pend_bank
	);
	assign pend_wr = pend_wr_g && take;

	jfop_back #(.PEND_DEPTH(PEND_DEPTH)) u_back (
		.clk, .arst_n, .cmd, .cmd_push(push), .cmd_full(full),
		.pend_wr, .pend_data, .pend_idx, .pend_bank, .result, .empty, .pop
	);
endmodule
